@@ hw/rtl/mhpc_pkg.sv @@
package mhpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_HEADER_BYTES  = 8;
  localparam int HEAD_BYTES        = 8;
  localparam int HEAD_W            = 8 * HEAD_BYTES;
  localparam int FREQ_W            = 33;
  localparam int LEN_W             = 4;
  localparam int PLEN_W            = 8;
  localparam int CODE_W            = 8;
  localparam int ENTRY_IDX_W       = 4;
  localparam int COUNT_W           = 5;
  // Wide enough to hold any table size up to 64 and any entry index or count.
  localparam int IDX_EXT_W         = 7;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    command;
    logic [ENTRY_IDX_W-1:0]  entry_index;
    logic [HEAD_W-1:0]       header_bytes;
    logic [HEAD_W-1:0]       mask_bytes;
    logic [LEN_W-1:0]        header_length;
    logic [FREQ_W-1:0]       freq_low;
    logic [FREQ_W-1:0]       freq_high;
    logic [CODE_W-1:0]       protocol_code;
    logic [CODE_W-1:0]       modulation_code;
    logic [HEAD_W-1:0]       payload_head;
    logic [PLEN_W-1:0]       payload_length;
    logic [FREQ_W-1:0]       frequency;
  } in_item_t;

  typedef struct packed {
    logic                    known;
    logic [CODE_W-1:0]       protocol_id;
    logic [CODE_W-1:0]       modulation_id;
    logic                    confidence;
    logic [FREQ_W-1:0]       frequency_echo;
  } out_item_t;

  typedef struct packed {
    logic [HEAD_W-1:0]       pattern;
    logic [HEAD_W-1:0]       mask;
    logic [LEN_W-1:0]        length;
    logic [FREQ_W-1:0]       freq_low;
    logic [FREQ_W-1:0]       freq_high;
    logic [CODE_W-1:0]       protocol;
    logic [CODE_W-1:0]       modulation;
  } sig_entry_t;

  typedef struct packed {
    logic [HEAD_W-1:0]       payload;
    logic [PLEN_W-1:0]       plen;
    logic [FREQ_W-1:0]       freq;
  } probe_t;

endpackage

@@ hw/rtl/mhpc_sig_table.sv @@
module mhpc_sig_table #(
  parameter int TABLE_ENTRIES = mhpc_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [IDX_W-1:0]                  wr_idx,
  input  mhpc_pkg::sig_entry_t              wr_entry,
  input  logic [mhpc_pkg::COUNT_W-1:0]      count,
  input  mhpc_pkg::probe_t                  probe,
  output logic [TABLE_ENTRIES-1:0]          hi_vec,
  output logic [TABLE_ENTRIES-1:0]          lo_vec,
  input  logic [IDX_W-1:0]                  sel_idx,
  output logic [mhpc_pkg::CODE_W-1:0]       sel_protocol,
  output logic [mhpc_pkg::CODE_W-1:0]       sel_modulation
);
  import mhpc_pkg::*;

  sig_entry_t               sig_tbl [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sig_tbl[wr_idx] <= wr_entry;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    localparam logic [IDX_EXT_W-1:0] POS = IDX_EXT_W'(i);

    sig_entry_t        ent;
    logic [LEN_W-1:0]  eff_len;
    logic [HEAD_W-1:0] diff;
    logic [HEAD_BYTES-1:0] byte_ok;
    logic              active;
    logic              len_ok;
    logic              hdr_ok;
    logic              win_set;
    logic              in_win;

    // An entry never written reads as all zero.
    assign ent = entry_vld[i] ? sig_tbl[i] : '0;

    always_comb begin
      eff_len = (ent.length > LEN_W'(MAX_HEADER_BYTES)) ? LEN_W'(MAX_HEADER_BYTES)
                                                         : ent.length;
      diff    = (probe.payload ^ ent.pattern) & ent.mask;
      for (int b = 0; b < HEAD_BYTES; b++) begin
        byte_ok[b] = (LEN_W'(b) >= eff_len) || (diff[8*b +: 8] == 8'd0);
      end
      active  = {{(IDX_EXT_W-COUNT_W){1'b0}}, count} > POS;
      len_ok  = (probe.plen != '0) && (probe.plen >= PLEN_W'(eff_len));
      hdr_ok  = active && len_ok && (&byte_ok);
      win_set = (ent.freq_low != '0) || (ent.freq_high != '0);
      in_win  = (probe.freq >= ent.freq_low) && (probe.freq <= ent.freq_high);
      hi_vec[i] = hdr_ok && win_set && in_win;
      lo_vec[i] = hdr_ok && !(win_set && in_win);
    end
  end

  always_comb begin
    if (entry_vld[sel_idx]) begin
      sel_protocol   = sig_tbl[sel_idx].protocol;
      sel_modulation = sig_tbl[sel_idx].modulation;
    end else begin
      sel_protocol   = '0;
      sel_modulation = '0;
    end
  end

endmodule

@@ hw/rtl/masked_header_protocol_classifier_top.sv @@
// A classify item passes the input register, the registered per-entry match flags
// and a priority select into the output register. Throughput: one item per cycle
// while out_ready holds; load items produce no result and update the table as they
// leave the first stage, ahead of any later item. A load leaves only when the match
// stage is free or moving, so an earlier item reads its codes first.
// Reset (synchronous, rst high) empties the pipeline, marks every table entry
// as unwritten (reads as zero) and clears signature_count.
module masked_header_protocol_classifier_top #(
  parameter int TABLE_ENTRIES = mhpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mhpc_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mhpc_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [mhpc_pkg::COUNT_W-1:0] cfg_wdata
);
  import mhpc_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [COUNT_W-1:0]       signature_count;

  in_item_t                 s1_item;
  logic                     s1_valid;
  logic                     s1_go;
  logic                     s1_load;

  logic [TABLE_ENTRIES-1:0] s2_hi;
  logic [TABLE_ENTRIES-1:0] s2_lo;
  logic [FREQ_W-1:0]        s2_freq;
  logic                     s2_valid;
  logic                     s2_go;
  logic                     s2_ready;
  logic                     s3_ready;

  logic [TABLE_ENTRIES-1:0] hi_vec;
  logic [TABLE_ENTRIES-1:0] lo_vec;
  logic [IDX_EXT_W-1:0]     wr_ext;
  logic                     wr_en;
  sig_entry_t               wr_entry;
  probe_t                   probe;

  logic [IDX_W-1:0]         hi_idx;
  logic [IDX_W-1:0]         lo_idx;
  logic [IDX_W-1:0]         sel_idx;
  logic [CODE_W-1:0]        sel_protocol;
  logic [CODE_W-1:0]        sel_modulation;
  out_item_t                result;

  always_ff @(posedge clk) begin
    if (rst) begin
      signature_count <= '0;
    end else if (cfg_we) begin
      signature_count <= cfg_wdata;
    end
  end

  // Handshake chain: each stage moves when the next one is free or moving.
  always_comb begin
    s3_ready = !out_valid || out_ready;
    s2_go    = s2_valid && s3_ready;
    s2_ready = !s2_valid || s3_ready;
    s1_load  = (s1_item.command == CMD_LOAD);
    // Hold a load while a stalled item ahead still reads its codes from the table.
    s1_go    = s1_valid && s2_ready;
    in_ready = !s1_valid || s1_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // Drop loads aimed past the table.
  always_comb begin
    wr_ext              = IDX_EXT_W'(s1_item.entry_index);
    wr_en               = s1_go && s1_load && (wr_ext < IDX_EXT_W'(TABLE_ENTRIES));
    wr_entry.pattern    = s1_item.header_bytes;
    wr_entry.mask       = s1_item.mask_bytes;
    wr_entry.length     = s1_item.header_length;
    wr_entry.freq_low   = s1_item.freq_low;
    wr_entry.freq_high  = s1_item.freq_high;
    wr_entry.protocol   = s1_item.protocol_code;
    wr_entry.modulation = s1_item.modulation_code;
    probe.payload       = s1_item.payload_head;
    probe.plen          = s1_item.payload_length;
    probe.freq          = s1_item.frequency;
  end

  mhpc_sig_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_sig_table (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_idx         (wr_ext[IDX_W-1:0]),
    .wr_entry       (wr_entry),
    .count          (signature_count),
    .probe          (probe),
    .hi_vec         (hi_vec),
    .lo_vec         (lo_vec),
    .sel_idx        (sel_idx),
    .sel_protocol   (sel_protocol),
    .sel_modulation (sel_modulation)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go && !s1_load) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_load) begin
      s2_hi   <= hi_vec;
      s2_lo   <= lo_vec;
      s2_freq <= s1_item.frequency;
    end
  end

  // First set bit wins in each vector; a windowed hit beats any plain hit.
  always_comb begin
    hi_idx = '0;
    lo_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (s2_hi[i]) begin
        hi_idx = IDX_W'(i);
      end
      if (s2_lo[i]) begin
        lo_idx = IDX_W'(i);
      end
    end
    sel_idx               = (|s2_hi) ? hi_idx : lo_idx;
    result.known          = (|s2_hi) || (|s2_lo);
    result.confidence     = |s2_hi;
    result.protocol_id    = result.known ? sel_protocol : '0;
    result.modulation_id  = result.known ? sel_modulation : '0;
    result.frequency_echo = s2_freq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_item <= result;
    end
  end

endmodule
